### rtl/pcm_pkg.sv
package pcm_pkg;

  localparam int PIXEL_BITS_DEF    = 12;
  localparam int FRAC_BITS_DEF     = 16;
  localparam int CORDIC_STAGES_DEF = 16;

  localparam int ANG_FB      = 24;
  localparam int DIST_FB     = 16;
  localparam int ZW          = 35;
  localparam int AW          = 33;
  localparam int QB          = 32;
  localparam int DIV_LAT     = QB + 3;
  localparam int INV_GAIN_W  = 28;
  localparam logic [INV_GAIN_W-1:0] INV_GAIN_Q28 = 28'd163008219;

  typedef enum logic [1:0] {
    OP_PIX2DATA = 2'd0,
    OP_VAL2DEG  = 2'd1,
    OP_VAL2PIX  = 2'd2,
    OP_NONE     = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_ZERO_SPAN = 2'd1,
    ST_SAT       = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    REG_CENTER_X   = 3'd0,
    REG_CENTER_Y   = 3'd1,
    REG_RADIUS     = 3'd2,
    REG_ANGLE_MIN  = 3'd3,
    REG_ANGLE_MAX  = 3'd4,
    REG_RADIAL_MIN = 3'd5,
    REG_RADIAL_MAX = 3'd6
  } reg_idx_t;

  // Arctangent of 2^-idx in degrees with 24 fraction bits.
  function automatic logic signed [ZW-1:0] atan_deg(input int idx);
    logic signed [ZW-1:0] r;
    case (idx)
      0:  r = 35'sd754974720;
      1:  r = 35'sd445687602;
      2:  r = 35'sd235489088;
      3:  r = 35'sd119537938;
      4:  r = 35'sd60000934;
      5:  r = 35'sd30029717;
      6:  r = 35'sd15018523;
      7:  r = 35'sd7509720;
      8:  r = 35'sd3754917;
      9:  r = 35'sd1877466;
      10: r = 35'sd938734;
      11: r = 35'sd469367;
      12: r = 35'sd234684;
      13: r = 35'sd117342;
      14: r = 35'sd58671;
      15: r = 35'sd29335;
      16: r = 35'sd14668;
      17: r = 35'sd7334;
      18: r = 35'sd3667;
      19: r = 35'sd1833;
      20: r = 35'sd917;
      21: r = 35'sd458;
      22: r = 35'sd229;
      23: r = 35'sd115;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

### rtl/pcm_muldiv.sv
module pcm_muldiv #(
  parameter int BW = 25,
  parameter int CW = 33
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic [pcm_pkg::AW-1:0]   a_i,
  input  logic [BW-1:0]            b_i,
  input  logic [CW-1:0]            c_i,
  output logic [pcm_pkg::QB-1:0]   q_o,
  output logic                     big_o
);

  localparam int AW  = pcm_pkg::AW;
  localparam int QB  = pcm_pkg::QB;
  localparam int ALO = (AW + 1) / 2;
  localparam int AHI = AW - ALO;
  localparam int PLW = ALO + BW;
  localparam int PHW = AHI + BW;
  localparam int NW  = AW + BW + 1;

  logic [PLW-1:0] pl_r;
  logic [PHW-1:0] ph_r;
  logic [CW-1:0]  c0_r;
  logic [NW-1:0]  n1_r;
  logic [CW-1:0]  c1_r;
  logic [NW-1:0]  hi_nxt;

  logic [CW-1:0] rem_r [0:QB];
  logic [QB-1:0] low_r [0:QB];
  logic [QB-1:0] q_r   [0:QB];
  logic          big_r [0:QB];
  logic [CW-1:0] c_r   [0:QB];

  assign hi_nxt = n1_r >> QB;

  always_ff @(posedge clk) begin
    if (en) begin
      pl_r <= PLW'(a_i[ALO-1:0]) * PLW'(b_i);
      ph_r <= PHW'(a_i[AW-1:ALO]) * PHW'(b_i);
      c0_r <= c_i;
      n1_r <= NW'(pl_r) + (NW'(ph_r) << ALO) + NW'(c0_r >> 1);
      c1_r <= c0_r;
      rem_r[0] <= CW'(hi_nxt);
      low_r[0] <= n1_r[QB-1:0];
      q_r[0]   <= '0;
      big_r[0] <= hi_nxt >= NW'(c1_r);
      c_r[0]   <= c1_r;
      for (int k = 0; k < QB; k++) begin
        logic [CW:0] t;
        logic        ge;
        t  = {rem_r[k], low_r[k][QB-1]};
        ge = t >= {1'b0, c_r[k]};
        rem_r[k+1] <= ge ? CW'(t - {1'b0, c_r[k]}) : CW'(t);
        low_r[k+1] <= low_r[k] << 1;
        q_r[k+1]   <= {q_r[k][QB-2:0], ge};
        big_r[k+1] <= big_r[k];
        c_r[k+1]   <= c_r[k];
      end
    end
  end

  assign q_o   = q_r[QB];
  assign big_o = big_r[QB];

endmodule

### rtl/polar_chart_coordinate_mapper_unit.sv
// Polar chart coordinate mapper. One word enters per clock and one result word leaves per
// clock while no output word waits untaken; when the output is not taken the whole pipeline
// holds. Each word passes the CORDIC stages and the 32-step restoring divider pipeline that
// does the rounded scalings. The user writes registers through the APB port only while no
// word is in flight; the block itself does not enforce this.
module polar_chart_coordinate_mapper_unit #(
  parameter int PIXEL_BITS    = pcm_pkg::PIXEL_BITS_DEF,
  parameter int FRAC_BITS     = pcm_pkg::FRAC_BITS_DEF,
  parameter int CORDIC_STAGES = pcm_pkg::CORDIC_STAGES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [4:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            in_opcode,
  input  logic [PIXEL_BITS-1:0] in_pixel_x,
  input  logic [PIXEL_BITS-1:0] in_pixel_y,
  input  logic signed [31:0]    in_data_value,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic signed [31:0]    out_first_result,
  output logic signed [31:0]    out_second_result,
  output logic [1:0]            out_status
);

  localparam int AW      = pcm_pkg::AW;
  localparam int QB      = pcm_pkg::QB;
  localparam int ZW      = pcm_pkg::ZW;
  localparam int PB      = PIXEL_BITS;
  localparam int DXW     = PB + 1;
  localparam int XW      = PB + 19;
  localparam int XUW     = XW - 1;
  localparam int DW      = PB + 17;
  localparam int PW      = XUW + pcm_pkg::INV_GAIN_W;
  localparam int TW      = FRAC_BITS + 9;
  localparam int CWB     = PB + pcm_pkg::DIST_FB;
  localparam int SHR     = pcm_pkg::ANG_FB - FRAC_BITS;
  localparam longint RND = (SHR > 0) ? (longint'(1) << (SHR - 1)) : 0;
  localparam int LAST    = CORDIC_STAGES + 2 + pcm_pkg::DIV_LAT;
  localparam logic [TW-1:0]        TURNF  = TW'(360) << FRAC_BITS;
  localparam logic signed [ZW-1:0] TURN24 = ZW'(360) << pcm_pkg::ANG_FB;
  localparam logic signed [ZW-1:0] HALF24 = ZW'(180) << pcm_pkg::ANG_FB;

  typedef struct packed {
    pcm_pkg::op_t  op;
    logic          center;
    logic          neg;
    logic [AW-1:0] opa;
  } meta_t;

  logic [PB-1:0]      cen_x_r, cen_y_r, rad_r;
  logic signed [31:0] amin_r, amax_r, rmin_r, rmax_r;
  logic [PB-1:0]      rad_eff;
  logic signed [32:0] spa, spr;
  logic [AW-1:0]      spa_mag, spr_mag;
  logic               adv;

  logic               wr_en;
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cen_x_r <= '0;
      cen_y_r <= '0;
      rad_r   <= PB'(1);
      amin_r  <= '0;
      amax_r  <= 32'sd1 <<< FRAC_BITS;
      rmin_r  <= '0;
      rmax_r  <= 32'sd1 <<< FRAC_BITS;
    end else if (wr_en) begin
      unique case (paddr[4:2])
        pcm_pkg::REG_CENTER_X:   cen_x_r <= pwdata[PB-1:0];
        pcm_pkg::REG_CENTER_Y:   cen_y_r <= pwdata[PB-1:0];
        pcm_pkg::REG_RADIUS:     rad_r   <= pwdata[PB-1:0];
        pcm_pkg::REG_ANGLE_MIN:  amin_r  <= pwdata;
        pcm_pkg::REG_ANGLE_MAX:  amax_r  <= pwdata;
        pcm_pkg::REG_RADIAL_MIN: rmin_r  <= pwdata;
        pcm_pkg::REG_RADIAL_MAX: rmax_r  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      pcm_pkg::REG_CENTER_X:   prdata = 32'(cen_x_r);
      pcm_pkg::REG_CENTER_Y:   prdata = 32'(cen_y_r);
      pcm_pkg::REG_RADIUS:     prdata = 32'(rad_r);
      pcm_pkg::REG_ANGLE_MIN:  prdata = amin_r;
      pcm_pkg::REG_ANGLE_MAX:  prdata = amax_r;
      pcm_pkg::REG_RADIAL_MIN: prdata = rmin_r;
      pcm_pkg::REG_RADIAL_MAX: prdata = rmax_r;
      default:                 prdata = '0;
    endcase
  end

  assign rad_eff = (rad_r == '0) ? PB'(1) : rad_r;
  assign spa     = 33'(amax_r) - 33'(amin_r);
  assign spr     = 33'(rmax_r) - 33'(rmin_r);
  assign spa_mag = spa[32] ? AW'(-spa) : AW'(spa);
  assign spr_mag = spr[32] ? AW'(-spr) : AW'(spr);

  // Input stage.
  logic signed [DXW-1:0] dx, dy;
  logic signed [XW-1:0]  x0_nxt, y0_nxt;
  logic signed [ZW-1:0]  z0_nxt;
  logic signed [32:0]    diff, vclamp;
  meta_t                 meta0_nxt;

  always_comb begin
    dx = signed'({1'b0, in_pixel_x}) - signed'({1'b0, cen_x_r});
    dy = signed'({1'b0, in_pixel_y}) - signed'({1'b0, cen_y_r});
    if (dy > 0) begin
      x0_nxt = XW'(dy) <<< pcm_pkg::DIST_FB;
      y0_nxt = -(XW'(dx) <<< pcm_pkg::DIST_FB);
      z0_nxt = HALF24;
    end else begin
      x0_nxt = -(XW'(dy) <<< pcm_pkg::DIST_FB);
      y0_nxt = XW'(dx) <<< pcm_pkg::DIST_FB;
      z0_nxt = '0;
    end
    diff   = 33'(in_data_value) - 33'(amin_r);
    vclamp = (in_data_value < rmin_r) ? 33'(rmin_r) : 33'(in_data_value);
    meta0_nxt.op     = pcm_pkg::op_t'(in_opcode);
    meta0_nxt.center = (dx == '0) && (dy == '0);
    if (in_opcode == pcm_pkg::OP_VAL2PIX) begin
      meta0_nxt.neg = spr[32];
      meta0_nxt.opa = AW'(vclamp - 33'(rmin_r));
    end else begin
      meta0_nxt.neg = diff[32] ^ spa[32];
      meta0_nxt.opa = diff[32] ? AW'(-diff) : AW'(diff);
    end
  end

  logic                 vld_r  [0:LAST];
  meta_t                meta_r [0:LAST];
  logic signed [XW-1:0] crd_x_r [0:CORDIC_STAGES];
  logic signed [XW-1:0] crd_y_r [0:CORDIC_STAGES];
  logic signed [ZW-1:0] crd_z_r [0:CORDIC_STAGES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= LAST; k++) begin
        vld_r[k] <= 1'b0;
      end
    end else if (adv) begin
      vld_r[0] <= in_valid;
      for (int k = 0; k < LAST; k++) begin
        vld_r[k+1] <= vld_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      meta_r[0]  <= meta0_nxt;
      crd_x_r[0] <= x0_nxt;
      crd_y_r[0] <= y0_nxt;
      crd_z_r[0] <= z0_nxt;
      for (int k = 0; k < LAST; k++) begin
        meta_r[k+1] <= meta_r[k];
      end
      for (int i = 0; i < CORDIC_STAGES; i++) begin
        if (crd_y_r[i] > 0) begin
          crd_x_r[i+1] <= crd_x_r[i] + (crd_y_r[i] >>> i);
          crd_y_r[i+1] <= crd_y_r[i] - (crd_x_r[i] >>> i);
          crd_z_r[i+1] <= crd_z_r[i] + pcm_pkg::atan_deg(i);
        end else begin
          crd_x_r[i+1] <= crd_x_r[i] - (crd_y_r[i] >>> i);
          crd_y_r[i+1] <= crd_y_r[i] + (crd_x_r[i] >>> i);
          crd_z_r[i+1] <= crd_z_r[i] - pcm_pkg::atan_deg(i);
        end
      end
    end
  end

  // Angle wrap and rounding, gain correction of the distance.
  logic signed [ZW-1:0] zw_r, zw_nxt, ar;
  logic [PW-1:0]        prod_r, prod_nxt;
  logic [TW-1:0]        a_r, a_nxt, a_t;
  logic [DW-1:0]        d_r, d_nxt;

  always_comb begin
    if (crd_z_r[CORDIC_STAGES] < 0) begin
      zw_nxt = crd_z_r[CORDIC_STAGES] + TURN24;
    end else if (crd_z_r[CORDIC_STAGES] >= TURN24) begin
      zw_nxt = crd_z_r[CORDIC_STAGES] - TURN24;
    end else begin
      zw_nxt = crd_z_r[CORDIC_STAGES];
    end
    prod_nxt = PW'(crd_x_r[CORDIC_STAGES][XUW-1:0]) * PW'(pcm_pkg::INV_GAIN_Q28);
    ar       = (zw_r + ZW'(RND)) >>> SHR;
    a_t      = TW'(ar);
    a_nxt    = (a_t >= TURNF) ? a_t - TURNF : a_t;
    d_nxt    = DW'((prod_r + (PW'(1) << 27)) >> 28);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      zw_r   <= zw_nxt;
      prod_r <= prod_nxt;
      a_r    <= a_nxt;
      d_r    <= d_nxt;
    end
  end

  // Divider operands.
  meta_t         mw;
  logic [AW-1:0] da_a;
  logic [TW-1:0] da_b;
  logic [AW-1:0] da_c;
  logic [CWB-1:0] db_c;

  assign mw = meta_r[CORDIC_STAGES+2];

  always_comb begin
    case (mw.op)
      pcm_pkg::OP_PIX2DATA: begin
        da_a = spa_mag;
        da_b = a_r;
        da_c = AW'(TURNF);
      end
      pcm_pkg::OP_VAL2DEG: begin
        da_a = mw.opa;
        da_b = TURNF;
        da_c = spa_mag;
      end
      default: begin
        da_a = mw.opa;
        da_b = TW'(rad_eff);
        da_c = spr_mag;
      end
    endcase
    db_c = CWB'(rad_eff) << pcm_pkg::DIST_FB;
  end

  logic [QB-1:0] q_a, q_b;
  logic          big_a, big_b;

  pcm_muldiv #(.BW(TW), .CW(AW)) u_div_a (
    .clk   (clk),
    .en    (adv),
    .a_i   (da_a),
    .b_i   (da_b),
    .c_i   (da_c),
    .q_o   (q_a),
    .big_o (big_a)
  );

  pcm_muldiv #(.BW(DW), .CW(CWB)) u_div_b (
    .clk   (clk),
    .en    (adv),
    .a_i   (spr_mag),
    .b_i   (d_r),
    .c_i   (db_c),
    .q_o   (q_b),
    .big_o (big_b)
  );

  function automatic logic [32:0] sat_add(input logic signed [31:0] base, input logic neg,
                                          input logic [32:0] mag);
    logic signed [34:0] bs, ms, v;
    bs = 35'(base);
    ms = signed'(35'(mag));
    v  = neg ? bs - ms : bs + ms;
    if (v > 35'sd2147483647) begin
      return {1'b1, 32'h7fff_ffff};
    end else if (v < -35'sd2147483648) begin
      return {1'b1, 32'h8000_0000};
    end else begin
      return {1'b0, v[31:0]};
    end
  endfunction

  // Output stage.
  meta_t              mo;
  logic [32:0]        mag_a, mag_b, ra, rb;
  logic signed [31:0] first_r, first_nxt, second_r, second_nxt;
  pcm_pkg::status_t   status_r, status_nxt;
  logic               out_valid_r;

  assign mo    = meta_r[LAST];
  assign mag_a = big_a ? 33'h1_0000_0000 : {1'b0, q_a};
  assign mag_b = big_b ? 33'h1_0000_0000 : {1'b0, q_b};

  always_comb begin
    first_nxt  = '0;
    second_nxt = '0;
    status_nxt = pcm_pkg::ST_OK;
    ra         = '0;
    rb         = '0;
    case (mo.op)
      pcm_pkg::OP_PIX2DATA: begin
        if (mo.center) begin
          first_nxt  = amin_r;
          second_nxt = rmin_r;
        end else begin
          ra         = sat_add(amin_r, spa[32], mag_a);
          rb         = sat_add(rmin_r, spr[32], mag_b);
          first_nxt  = ra[31:0];
          second_nxt = rb[31:0];
          if (ra[32] || rb[32]) begin
            status_nxt = pcm_pkg::ST_SAT;
          end
        end
      end
      pcm_pkg::OP_VAL2DEG, pcm_pkg::OP_VAL2PIX: begin
        if ((mo.op == pcm_pkg::OP_VAL2DEG) ? (spa == '0) : (spr == '0)) begin
          status_nxt = pcm_pkg::ST_ZERO_SPAN;
        end else begin
          ra        = sat_add(32'sd0, mo.neg, mag_a);
          first_nxt = ra[31:0];
          if (ra[32]) begin
            status_nxt = pcm_pkg::ST_SAT;
          end
        end
      end
      default: ;
    endcase
  end

  assign adv = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= vld_r[LAST];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      first_r  <= first_nxt;
      second_r <= second_nxt;
      status_r <= status_nxt;
    end
  end

  assign in_ready          = adv;
  assign out_valid         = out_valid_r;
  assign out_first_result  = first_r;
  assign out_second_result = second_r;
  assign out_status        = status_r;

endmodule
